// ----- hdl/assert_macros.svh -----
// assertion macros shared by the direction update rtl
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every rising clock edge, off while in reset
`define BRDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// condition that must never be seen
`define BRDU_ASSERT_NEVER(lbl, cond, msg) \
  `BRDU_ASSERT(lbl, !(cond), msg)
`endif

// ----- hdl/brdu_pkg.sv -----
// package for the biased random direction update block
// types, constants and the arctangent table; no dependencies
`timescale 1ns / 1ps

package brdu_pkg;

  localparam int DIR_FRAC_BITS = 14;
  localparam int CORDIC_STAGES = 16;

  localparam int DIR_W      = 16;
  localparam int TS_W       = 32;
  localparam int PERS_W     = 32;
  localparam int WGT_W      = 17;
  localparam int RAND_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TS_W-1:0] TIME_STEP_RST = 32'd65536;
  localparam logic            MOT_EN_RST    = 1'b1;

  localparam int FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP       = 1'b0,
    REG_MOTILITY_ENABLE = 1'b1
  } brdu_reg_e;

  typedef struct packed {
    logic                    motile;
    logic [PERS_W-1:0]       persistence;
    logic [WGT_W-1:0]        bias_weight;
    logic signed [DIR_W-1:0] bias_x;
    logic signed [DIR_W-1:0] bias_y;
    logic signed [DIR_W-1:0] bias_z;
    logic signed [DIR_W-1:0] old_dir_x;
    logic signed [DIR_W-1:0] old_dir_y;
    logic signed [DIR_W-1:0] old_dir_z;
    logic [RAND_W-1:0]       rand_event;
    logic [RAND_W-1:0]       rand_theta;
    logic [RAND_W-1:0]       rand_polar;
  } brdu_in_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] new_dir_x;
    logic signed [DIR_W-1:0] new_dir_y;
    logic signed [DIR_W-1:0] new_dir_z;
    logic                    turned;
  } brdu_out_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic     turn;
    brdu_in_t item;
  } brdu_task_t;

  // arctangent of 2^-i in q2.30, truncated
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd843314856;
      1:  r = 32'd497837829;
      2:  r = 32'd263043836;
      3:  r = 32'd133525158;
      4:  r = 32'd67021686;
      5:  r = 32'd33543515;
      6:  r = 32'd16775850;
      7:  r = 32'd8388437;
      8:  r = 32'd4194282;
      9:  r = 32'd2097149;
      10: r = 32'd1048575;
      11: r = 32'd524287;
      12: r = 32'd262143;
      13: r = 32'd131071;
      14: r = 32'd65535;
      15: r = 32'd32767;
      16: r = 32'd16383;
      17: r = 32'd8191;
      18: r = 32'd4095;
      19: r = 32'd2047;
      20: r = 32'd1023;
      21: r = 32'd511;
      22: r = 32'd255;
      23: r = 32'd127;
      24: r = 32'd63;
      25: r = 32'd31;
      26: r = 32'd15;
      27: r = 32'd7;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/brdu_front.sv -----
// front end: config registers, transaction accept and turn decision
// depends on brdu_pkg
`timescale 1ns / 1ps

module brdu_front import brdu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  brdu_in_t              in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output brdu_task_t            task_o,
  output logic                  task_vld_o,
  input  logic                  task_rdy_i
);

  logic [TS_W-1:0] time_step_q;
  logic            mot_en_q;
  logic            vld_q, vld_d;
  brdu_task_t      task_q;
  logic [PERS_W+RAND_W-1:0] prod;
  logic [PERS_W+RAND_W-1:0] limit;
  logic            ready;
  logic            accept;
  logic            turn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
      mot_en_q    <= MOT_EN_RST;
    end else if (cfg_we_i) begin
      case (brdu_reg_e'(cfg_idx_i))
        REG_TIME_STEP:       time_step_q <= cfg_data_i[TS_W-1:0];
        REG_MOTILITY_ENABLE: mot_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign prod  = (PERS_W+RAND_W)'(in_i.rand_event) * (PERS_W+RAND_W)'(in_i.persistence);
  assign limit = {time_step_q, {RAND_W{1'b0}}};
  assign turn  = mot_en_q && in_i.motile && (in_i.persistence != '0) && (prod < limit);

  assign ready  = !vld_q || task_rdy_i;
  assign accept = start_i && ready;
  assign busy_o = !ready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (task_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      task_q <= '{turn: turn, item: in_i};
    end
  end

  assign task_o     = task_q;
  assign task_vld_o = vld_q;

endmodule

// ----- hdl/brdu_fifo.sv -----
// short queue of classified transactions between front and back
// depends on brdu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brdu_fifo import brdu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  brdu_task_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output brdu_task_t data_o,
  output logic       vld_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  brdu_task_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `BRDU_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
  `BRDU_ASSERT(a_no_underflow, pop_i |-> vld_o, "pop from an empty queue")

endmodule

// ----- hdl/brdu_back.sv -----
// back end: random draw, cordic, blend, magnitude and normalising divide
// depends on brdu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brdu_back import brdu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  brdu_task_t task_i,
  output logic       vld_o,
  output brdu_out_t  res_o
);

  localparam int SQ1_STEPS  = 17;
  localparam int NS1        = (CORDIC_STAGES > SQ1_STEPS) ? CORDIC_STAGES : SQ1_STEPS;
  localparam int CORDIC_RUN = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int C_W        = 34;
  localparam int RV_W       = 34;
  localparam int BV_W       = 33;
  localparam int P_W        = 52;
  localparam int D_W        = 34;
  localparam int A_W        = 32;
  localparam int SUM_W      = 64;
  localparam int SQ2_STEPS  = 32;
  localparam int DIV_STEPS  = DIR_FRAC_BITS + 1;
  localparam int NUM_W      = A_W + DIR_FRAC_BITS + 1;
  localparam int OUT_LIM    = ((1 << DIR_FRAC_BITS) < 32767) ? (1 << DIR_FRAC_BITS) : 32767;
  localparam int BIAS_SH    = 30 - DIR_FRAC_BITS;
  localparam int BACK_LAT   = 1 + NS1 + 5 + SQ2_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [DIV_STEPS-1:0]   Q_LIM     = DIV_STEPS'(OUT_LIM);
  localparam logic signed [47:0]     BIAS_LIM  = 48'sd2147483648;
  localparam logic signed [C_W-1:0]  GAIN      = 34'sd652032874;
  localparam logic [30:0]            ANG_SCALE = 31'd1686629713;
  localparam logic signed [35:0]     ONE_Q32   = 36'sh1_0000_0000;
  localparam logic signed [17:0]     ONE_Q16   = 18'sd65536;
  localparam logic [WGT_W-1:0]       W_ONE     = 17'd65536;

  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic             turn;
    logic [DIR_W-1:0] old_x;
    logic [DIR_W-1:0] old_y;
    logic [DIR_W-1:0] old_z;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic [32:0]             rad;
    logic [33:0]             r;
    logic signed [C_W-1:0]   cx;
    logic signed [C_W-1:0]   cy;
    logic signed [C_W-1:0]   ang;
    logic [1:0]              quad;
    logic signed [RV_W-1:0]  rvz;
    logic signed [BV_W-1:0]  bx;
    logic signed [BV_W-1:0]  by;
    logic signed [BV_W-1:0]  bz;
    logic [WGT_W-1:0]        w;
  } s1_t;

  typedef struct packed {
    side_t                  side;
    logic [SUM_W-1:0]       rad;
    logic [SUM_W-1:0]       r;
    logic [2:0][A_W-1:0]    a;
    logic [2:0]             neg;
    logic                   zero;
  } s2_t;

  typedef struct packed {
    side_t                     side;
    logic [A_W-1:0]            mag;
    logic [2:0][NUM_W-1:0]     rem;
    logic [2:0][DIV_STEPS-1:0] q;
    logic [2:0]                neg;
    logic                      zero;
  } s3_t;

  function automatic logic signed [BV_W-1:0] bias_q30(input logic signed [DIR_W-1:0] v);
    logic signed [47:0] t;
    t = $signed({{(48-DIR_W){v[DIR_W-1]}}, v}) <<< BIAS_SH;
    if (t > BIAS_LIM) begin
      t = BIAS_LIM;
    end else if (t < -BIAS_LIM) begin
      t = -BIAS_LIM;
    end
    return BV_W'(t);
  endfunction

  // entry stage: polar cosine, radicand, start angle, bias in q30

  logic signed [17:0] z16;
  logic signed [35:0] zsq;
  logic [44:0]        angp;
  logic [WGT_W-1:0]   w_sat;

  assign z16   = $signed({1'b0, task_i.item.rand_polar, 1'b0}) - ONE_Q16;
  assign zsq   = z16 * z16;
  assign angp  = 45'(task_i.item.rand_theta[13:0]) * 45'(ANG_SCALE);
  assign w_sat = (task_i.item.bias_weight > W_ONE) ? W_ONE : task_i.item.bias_weight;

  s1_t  s1_q [NS1+1];
  logic v1_q [NS1+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q[0] <= 1'b0;
    end else begin
      v1_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q[0].side <= '{turn: task_i.turn, old_x: task_i.item.old_dir_x,
                      old_y: task_i.item.old_dir_y, old_z: task_i.item.old_dir_z};
    s1_q[0].rad  <= 33'(ONE_Q32 - zsq);
    s1_q[0].r    <= '0;
    s1_q[0].cx   <= GAIN;
    s1_q[0].cy   <= '0;
    s1_q[0].ang  <= $signed({3'b000, angp[44:14]});
    s1_q[0].quad <= task_i.item.rand_theta[15:14];
    s1_q[0].rvz  <= $signed({{(RV_W-18){z16[17]}}, z16}) <<< 14;
    s1_q[0].bx   <= bias_q30(task_i.item.bias_x);
    s1_q[0].by   <= bias_q30(task_i.item.bias_y);
    s1_q[0].bz   <= bias_q30(task_i.item.bias_z);
    s1_q[0].w    <= w_sat;
  end

  // square root of sin^2 and cordic rotation side by side

  for (genvar i = 0; i < NS1; i++) begin : g_s1
    localparam int SB = (i < SQ1_STEPS) ? 2 * (SQ1_STEPS - 1 - i) : 0;
    localparam logic signed [C_W-1:0] ATAN_I = $signed({2'b00, atan_q30(i)});
    s1_t                   s1_d;
    logic [34:0]           rb;
    logic signed [C_W-1:0] dx, dy;

    assign rb = 35'(s1_q[i].r) + (35'd1 << SB);
    assign dx = $signed(s1_q[i].cy) >>> i;
    assign dy = $signed(s1_q[i].cx) >>> i;

    always_comb begin
      s1_d = s1_q[i];
      if (i < SQ1_STEPS) begin
        if (35'(s1_q[i].rad) >= rb) begin
          s1_d.rad = 33'(35'(s1_q[i].rad) - rb);
          s1_d.r   = (s1_q[i].r >> 1) + (34'd1 << SB);
        end else begin
          s1_d.r   = s1_q[i].r >> 1;
        end
      end
      if (i < CORDIC_RUN) begin
        if (!s1_q[i].ang[C_W-1]) begin
          s1_d.cx  = $signed(s1_q[i].cx) - dx;
          s1_d.cy  = $signed(s1_q[i].cy) + dy;
          s1_d.ang = $signed(s1_q[i].ang) - ATAN_I;
        end else begin
          s1_d.cx  = $signed(s1_q[i].cx) + dx;
          s1_d.cy  = $signed(s1_q[i].cy) - dy;
          s1_d.ang = $signed(s1_q[i].ang) + ATAN_I;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[i+1] <= 1'b0;
      end else begin
        v1_q[i+1] <= v1_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      s1_q[i+1] <= s1_d;
    end
  end

  // quadrant fold and scale by sin(phi)

  s1_t                   f1;
  logic signed [C_W-1:0] rcx, rcy;
  logic signed [17:0]    s16;
  logic signed [51:0]    prx, pry;

  assign f1  = s1_q[NS1];
  assign s16 = $signed({1'b0, f1.r[16:0]});

  always_comb begin
    rcx = $signed(f1.cx);
    rcy = $signed(f1.cy);
    case (f1.quad)
      QUAD_1: begin
        rcx = -$signed(f1.cy);
        rcy = $signed(f1.cx);
      end
      QUAD_2: begin
        rcx = -$signed(f1.cx);
        rcy = -$signed(f1.cy);
      end
      QUAD_3: begin
        rcx = $signed(f1.cy);
        rcy = -$signed(f1.cx);
      end
      default: ;
    endcase
  end

  assign prx = s16 * rcx;
  assign pry = s16 * rcy;

  side_t                  side_r_q;
  logic                   vr_q;
  logic signed [RV_W-1:0] rv_q [3];
  logic signed [BV_W-1:0] bv_q [3];
  logic [WGT_W-1:0]       w_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= v1_q[NS1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_r_q <= f1.side;
    rv_q[0]  <= RV_W'(prx >>> 16);
    rv_q[1]  <= RV_W'(pry >>> 16);
    rv_q[2]  <= $signed(f1.rvz);
    bv_q[0]  <= $signed(f1.bx);
    bv_q[1]  <= $signed(f1.by);
    bv_q[2]  <= $signed(f1.bz);
    w_r_q    <= f1.w;
  end

  // blend products

  logic signed [17:0]    wc, wb;
  side_t                 side_m_q;
  logic                  vm_q;
  logic signed [P_W-1:0] pa_q [3];
  logic signed [P_W-1:0] pb_q [3];

  assign wc = ONE_Q16 - $signed({1'b0, w_r_q});
  assign wb = $signed({1'b0, w_r_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_m_q <= side_r_q;
    for (int k = 0; k < 3; k++) begin
      pa_q[k] <= wc * rv_q[k];
      pb_q[k] <= wb * bv_q[k];
    end
  end

  // blend sum, q28 component and its magnitude

  side_t                 side_d_q;
  logic                  vd_q;
  logic [A_W-1:0]        a_q [3];
  logic [2:0]            neg_q;
  logic signed [P_W-1:0] bl [3];
  logic signed [D_W-1:0] dv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bl[k] = pa_q[k] + pb_q[k];
      dv[k] = D_W'(bl[k] >>> 18);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_d_q <= side_m_q;
    for (int k = 0; k < 3; k++) begin
      neg_q[k] <= dv[k][D_W-1];
      a_q[k]   <= A_W'(dv[k][D_W-1] ? -dv[k] : dv[k]);
    end
  end

  // squares

  side_t            side_s_q;
  logic             vs_q;
  logic [SUM_W-1:0] sq_q [3];
  logic [A_W-1:0]   a_s_q [3];
  logic [2:0]       neg_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else begin
      vs_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_s_q <= side_d_q;
    neg_s_q  <= neg_q;
    for (int k = 0; k < 3; k++) begin
      sq_q[k]  <= SUM_W'(a_q[k]) * SUM_W'(a_q[k]);
      a_s_q[k] <= a_q[k];
    end
  end

  // sum of squares into the magnitude square root

  s2_t              s2_q [SQ2_STEPS+1];
  logic             v2_q [SQ2_STEPS+1];
  logic [SUM_W-1:0] sum;

  assign sum = sq_q[0] + sq_q[1] + sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q[0] <= 1'b0;
    end else begin
      v2_q[0] <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q[0].side <= side_s_q;
    s2_q[0].rad  <= sum;
    s2_q[0].r    <= '0;
    s2_q[0].a    <= {a_s_q[2], a_s_q[1], a_s_q[0]};
    s2_q[0].neg  <= neg_s_q;
    s2_q[0].zero <= (sum == '0);
  end

  for (genvar i = 0; i < SQ2_STEPS; i++) begin : g_s2
    localparam int SB = 2 * (SQ2_STEPS - 1 - i);
    s2_t          s2_d;
    logic [SUM_W:0] rb;

    assign rb = (SUM_W+1)'(s2_q[i].r) + ((SUM_W+1)'(1) << SB);

    always_comb begin
      s2_d = s2_q[i];
      if ((SUM_W+1)'(s2_q[i].rad) >= rb) begin
        s2_d.rad = SUM_W'((SUM_W+1)'(s2_q[i].rad) - rb);
        s2_d.r   = (s2_q[i].r >> 1) + (SUM_W'(1) << SB);
      end else begin
        s2_d.r   = s2_q[i].r >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[i+1] <= 1'b0;
      end else begin
        v2_q[i+1] <= v2_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      s2_q[i+1] <= s2_d;
    end
  end

  // rounding numerators and restoring divide by the magnitude

  s2_t            f2;
  logic [A_W-1:0] mag;
  s3_t            s3_q [DIV_STEPS+1];
  logic           v3_q [DIV_STEPS+1];

  assign f2  = s2_q[SQ2_STEPS];
  assign mag = f2.r[A_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q[0] <= 1'b0;
    end else begin
      v3_q[0] <= v2_q[SQ2_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q[0].side <= f2.side;
    s3_q[0].mag  <= mag;
    s3_q[0].neg  <= f2.neg;
    s3_q[0].zero <= f2.zero;
    s3_q[0].q    <= '0;
    for (int k = 0; k < 3; k++) begin
      s3_q[0].rem[k] <= (NUM_W'(f2.a[k]) << DIR_FRAC_BITS) + NUM_W'(mag >> 1);
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    s3_t            s3_d;
    logic [NUM_W-1:0] cmp;

    assign cmp = NUM_W'(s3_q[j].mag) << SH;

    always_comb begin
      s3_d = s3_q[j];
      for (int k = 0; k < 3; k++) begin
        if (s3_q[j].rem[k] >= cmp) begin
          s3_d.rem[k]    = s3_q[j].rem[k] - cmp;
          s3_d.q[k][SH]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v3_q[j+1] <= 1'b0;
      end else begin
        v3_q[j+1] <= v3_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      s3_q[j+1] <= s3_d;
    end
  end

  // clamp, sign and pass-through select

  s3_t                     f3;
  logic [DIV_STEPS-1:0]    qc [3];
  logic signed [DIR_W-1:0] lane [3];
  brdu_out_t               res_d, res_q;
  logic                    vo_q;

  assign f3 = s3_q[DIV_STEPS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k]   = (f3.q[k] > Q_LIM) ? Q_LIM : f3.q[k];
      lane[k] = f3.neg[k] ? -$signed(DIR_W'(qc[k])) : $signed(DIR_W'(qc[k]));
      if (f3.zero) begin
        lane[k] = '0;
      end
    end
    if (f3.side.turn) begin
      res_d = '{new_dir_x: lane[0], new_dir_y: lane[1], new_dir_z: lane[2], turned: 1'b1};
    end else begin
      res_d = '{new_dir_x: f3.side.old_x, new_dir_y: f3.side.old_y,
                new_dir_z: f3.side.old_z, turned: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v3_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = vo_q;
  assign res_o = res_q;

  `BRDU_ASSERT(a_no_spurious_result, vld_o |-> $past(vld_i, BACK_LAT), "result without transaction")
  `BRDU_ASSERT(a_no_lost_result, $past(vld_i, BACK_LAT) |-> vld_o, "transaction lost in pipeline")

endmodule

// ----- hdl/biased_random_direction_update.sv -----
// top level of the biased random direction update block
// depends on brdu_pkg, brdu_front, brdu_fifo and brdu_back
//
// one cell per transaction: drive in_i and raise start_i; the cell is taken
// at a rising edge where start_i is high and busy_o is low. the front end
// decides whether the cell turns, a two-entry queue decouples it from the
// back end, which is fully pipelined and takes one transaction per cycle.
// throughput: one cell per clock cycle, sustained while busy_o stays low.
// valid_o is high with result_o once the cell has passed the front register,
// the queue, the 17-step square root running beside the cordic, the 32-step
// magnitude square root, the 15-step restoring divide and the register
// stages between and after them.
// valid_o lasts one cycle per result and there is no back-pressure; results
// come out in the order the cells went in.
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i at once
// (0: time step, 1: motility enable); write only while the block is idle.
// reset: asynchronous, active low; empties the pipeline and restores the
// time step to 1.0 and motility to enabled.
`timescale 1ns / 1ps

module biased_random_direction_update import brdu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  brdu_in_t              in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  valid_o,
  output brdu_out_t             result_o
);

  brdu_task_t front_task, queue_task;
  logic       front_vld, queue_full, queue_vld;

  brdu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .task_o     (front_task),
    .task_vld_o (front_vld),
    .task_rdy_i (!queue_full)
  );

  brdu_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld),
    .data_i (front_task),
    .full_o (queue_full),
    .pop_i  (queue_vld),
    .data_o (queue_task),
    .vld_o  (queue_vld)
  );

  brdu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (queue_vld),
    .task_i (queue_task),
    .vld_o  (valid_o),
    .res_o  (result_o)
  );

endmodule
